>>> rtl/core/kpd_pkg.sv
// ---------------------------------------------------------------------------
// Keypad scanner package
// Shared widths, the scan encoder, the character table and the running-best
// word that is passed along the row of count cells.
// ---------------------------------------------------------------------------
package kpd_pkg;

  // Window length in ticks and number of key codes (code 0 is "no key").
  localparam int WINDOW_LEN = 3;
  localparam int KEY_CODES  = 13;

  // Field widths fixed by the interface.
  localparam int MATRIX_W = 12;
  localparam int CODE_W   = 4;
  localparam int CHAR_W   = 7;
  localparam int THR_W    = 2;

  // Counter width: a count can reach the window length.
  localparam int CNT_W = $clog2(WINDOW_LEN + 1);
  // Width used to compare a count against the threshold.
  localparam int CMP_W = (CNT_W > THR_W) ? CNT_W : THR_W;

  // Number of matrix bits that can yield a valid key code.
  localparam int SCAN_BITS = (KEY_CODES - 1 < MATRIX_W) ? (KEY_CODES - 1) : MATRIX_W;

  // Threshold after reset.
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(2);

  // ASCII codes of the key legends.
  localparam logic [CHAR_W-1:0] CHAR_NONE  = 7'h00;
  localparam logic [CHAR_W-1:0] CHAR_0     = 7'h30;
  localparam logic [CHAR_W-1:0] CHAR_1     = 7'h31;
  localparam logic [CHAR_W-1:0] CHAR_2     = 7'h32;
  localparam logic [CHAR_W-1:0] CHAR_3     = 7'h33;
  localparam logic [CHAR_W-1:0] CHAR_4     = 7'h34;
  localparam logic [CHAR_W-1:0] CHAR_5     = 7'h35;
  localparam logic [CHAR_W-1:0] CHAR_6     = 7'h36;
  localparam logic [CHAR_W-1:0] CHAR_7     = 7'h37;
  localparam logic [CHAR_W-1:0] CHAR_8     = 7'h38;
  localparam logic [CHAR_W-1:0] CHAR_9     = 7'h39;
  localparam logic [CHAR_W-1:0] CHAR_STAR  = 7'h2A;
  localparam logic [CHAR_W-1:0] CHAR_HASH  = 7'h23;

  // Running best passed from one count cell to the next.
  typedef struct packed {
    logic [CODE_W-1:0] idx;
    logic [CNT_W-1:0]  cnt;
  } best_t;

  // Priority encoder: the lowest set bit gives the key code, 0 for none.
  function automatic logic [CODE_W-1:0] scan_code(input logic [MATRIX_W-1:0] m);
    logic [CODE_W-1:0] code;
    code = '0;
    for (int b = SCAN_BITS - 1; b >= 0; b--) begin
      if (m[b]) begin
        code = CODE_W'(b + 1);
      end
    end
    return code;
  endfunction

  // Legend of each key, column-major with row 1 first.
  function automatic logic [CHAR_W-1:0] key_char(input logic [CODE_W-1:0] code);
    logic [CHAR_W-1:0] ch;
    unique case (code)
      4'd1:    ch = CHAR_1;
      4'd2:    ch = CHAR_4;
      4'd3:    ch = CHAR_7;
      4'd4:    ch = CHAR_STAR;
      4'd5:    ch = CHAR_2;
      4'd6:    ch = CHAR_5;
      4'd7:    ch = CHAR_8;
      4'd8:    ch = CHAR_0;
      4'd9:    ch = CHAR_3;
      4'd10:   ch = CHAR_6;
      4'd11:   ch = CHAR_9;
      4'd12:   ch = CHAR_HASH;
      default: ch = CHAR_NONE;
    endcase
    return ch;
  endfunction

endpackage

>>> rtl/core/keypad_scan_majority_debounce.sv
// ---------------------------------------------------------------------------
// Keypad scan with majority debounce
// Scans a 4x3 switch matrix, keeps a sliding window of key codes and
// reports the debounced key, its legend, a press event and the raw code.
// ---------------------------------------------------------------------------
// Usage:
//   Input channel: one switch-matrix word per tick on in_switch_matrix,
//   taken at a clock edge where in_valid is high and in_stall is low.
//   Output channel: one result word per input word, offered with out_valid
//   and taken where out_stall is low.
//   Configuration: cfg_we writes cfg_wdata into the press threshold; write
//   it only while no word is in flight.
//   Pipeline: two register stages, the window and count cells, then the
//   output register; a word in the window stage moves on to the output
//   register once that register is free or being taken.
//   Throughput: one word per cycle while out_stall is low; the window shift,
//   count update and argmax along the row of count cells all happen in the window stage.
//   Reset: the window holds "no key", the threshold is 2, no key is held and
//   the output is empty.
//   Stall: while out_stall holds a result, the next word waits in the
//   window stage and in_stall rises only once that stage is also full.
// ---------------------------------------------------------------------------
module keypad_scan_majority_debounce (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [kpd_pkg::THR_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [kpd_pkg::MATRIX_W-1:0] in_switch_matrix,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [kpd_pkg::CODE_W-1:0]   out_stable_key,
  output logic [kpd_pkg::CHAR_W-1:0]   out_stable_char,
  output logic                         out_press_event,
  output logic [kpd_pkg::CODE_W-1:0]   out_raw_key
);
  import kpd_pkg::*;

  logic [THR_W-1:0]  thr_val_r;
  logic              s1_valid_r;
  logic              s1_valid_nxt;
  logic [CODE_W-1:0] s1_raw_r;
  logic              out_valid_r;
  logic              out_valid_nxt;
  logic              key_held_r;
  logic              key_held_nxt;
  logic [CODE_W-1:0] out_stable_key_r;
  logic [CHAR_W-1:0] out_stable_char_r;
  logic              out_press_event_r;
  logic [CODE_W-1:0] out_raw_key_r;

  logic              in_acc;
  logic              s1_adv;
  logic [CODE_W-1:0] raw_code;
  logic [CODE_W-1:0] win_q [WINDOW_LEN+1];
  best_t             best_w [KEY_CODES+1];
  logic [CODE_W-1:0] stable_key;
  logic              press_ev;

  // Handshake: the window stage moves on whenever the output slot is free or being taken.
  assign s1_adv   = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !s1_adv;
  assign in_acc   = in_valid && !in_stall;

  assign raw_code = scan_code(in_switch_matrix);

  // Threshold register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_val_r <= THR_RESET;
    end else if (cfg_we) begin
      thr_val_r <= cfg_wdata;
    end
  end

  // Window row: the youngest slot takes the scanned code.
  assign win_q[WINDOW_LEN] = raw_code;

  for (genvar k = 0; k < WINDOW_LEN; k++) begin : g_win
    kpd_win_cell u_win (
      .clk      (clk),
      .rst_n    (rst_n),
      .load     (in_acc),
      .code_in  (win_q[k+1]),
      .code_out (win_q[k])
    );
  end

  // Count row: every cell sees the leaving and the entering code, and the
  // running best ripples from code 0 upwards.
  assign best_w[0] = '{idx: '0, cnt: '0};

  for (genvar i = 0; i < KEY_CODES; i++) begin : g_cnt
    kpd_cnt_cell u_cnt (
      .clk      (clk),
      .rst_n    (rst_n),
      .upd      (in_acc),
      .cell_idx (CODE_W'(i)),
      .oldest   (win_q[0]),
      .raw      (raw_code),
      .best_in  (best_w[i]),
      .best_out (best_w[i+1])
    );
  end

  // Debounced key and press edge for the word in the window stage.
  always_comb begin
    stable_key = '0;
    if (CMP_W'(best_w[KEY_CODES].cnt) >= CMP_W'(thr_val_r)) begin
      stable_key = best_w[KEY_CODES].idx;
    end
    press_ev     = 1'b0;
    key_held_nxt = key_held_r;
    if (s1_adv) begin
      if (stable_key == '0) begin
        key_held_nxt = 1'b0;
      end else if (!key_held_r) begin
        key_held_nxt = 1'b1;
        press_ev     = 1'b1;
      end
    end
  end

  // Stage valid flags.
  always_comb begin
    s1_valid_nxt  = in_acc ? 1'b1 : (s1_adv ? 1'b0 : s1_valid_r);
    out_valid_nxt = s1_adv ? 1'b1 : (out_valid_r && out_stall);
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      key_held_r  <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      key_held_r  <= key_held_nxt;
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_raw_r <= raw_code;
    end
    if (s1_adv) begin
      out_stable_key_r  <= stable_key;
      out_stable_char_r <= key_char(stable_key);
      out_press_event_r <= press_ev;
      out_raw_key_r     <= s1_raw_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_stable_key  = out_stable_key_r;
  assign out_stable_char = out_stable_char_r;
  assign out_press_event = out_press_event_r;
  assign out_raw_key     = out_raw_key_r;

`ifndef SYNTHESIS
  // A press event always names a key and leaves it held.
  a_event_has_key: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_press_event_r |-> (out_stable_key_r != '0) && key_held_r)
    else $error("press event without a held key");

  // The legend is blank exactly when no key is debounced.
  a_char_matches: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ((out_stable_char_r == CHAR_NONE) == (out_stable_key_r == '0)))
    else $error("legend and key code disagree");

  // Scanned codes stay within the key range.
  a_raw_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_raw_key_r < CODE_W'(KEY_CODES)))
    else $error("raw key code out of range");

  // A word blocked in the window stage keeps its raw code.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_raw_r))
    else $error("window stage lost a blocked word");

  // A held key cannot raise a second event on the next word.
  a_no_double_event: assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && key_held_r |-> !press_ev)
    else $error("second press event while key held");
`endif

endmodule

>>> rtl/core/kpd_win_cell.sv
// ---------------------------------------------------------------------------
// Keypad window cell
// One slot of the sliding code window. On each accepted word the slot takes
// the code of its younger neighbour, so the window shifts by one place.
// ---------------------------------------------------------------------------
module kpd_win_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic [kpd_pkg::CODE_W-1:0] code_in,
  output logic [kpd_pkg::CODE_W-1:0] code_out
);
  import kpd_pkg::*;

  logic [CODE_W-1:0] code_r;
  logic [CODE_W-1:0] code_nxt;

  // Take the neighbour's code when the window moves.
  always_comb begin
    code_nxt = load ? code_in : code_r;
  end

  // The window starts full of "no key".
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      code_r <= '0;
    end else begin
      code_r <= code_nxt;
    end
  end

  assign code_out = code_r;

endmodule

>>> rtl/core/kpd_cnt_cell.sv
// ---------------------------------------------------------------------------
// Keypad count cell
// Holds the window occurrence count of one key code. Updates it when a word
// is accepted and passes the running largest count on to the next cell.
// ---------------------------------------------------------------------------
module kpd_cnt_cell (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      upd,
  input  logic [kpd_pkg::CODE_W-1:0] cell_idx,
  input  logic [kpd_pkg::CODE_W-1:0] oldest,
  input  logic [kpd_pkg::CODE_W-1:0] raw,
  input  kpd_pkg::best_t            best_in,
  output kpd_pkg::best_t            best_out
);
  import kpd_pkg::*;

  logic [CNT_W-1:0] cnt_r;
  logic [CNT_W-1:0] cnt_nxt;
  logic [CNT_W-1:0] cnt_dec;

  // The oldest code leaves first, then the new code enters.
  always_comb begin
    cnt_dec = cnt_r;
    if ((oldest == cell_idx) && (cnt_r != '0)) begin
      cnt_dec = cnt_r - CNT_W'(1);
    end
    cnt_nxt = cnt_dec;
    if ((raw == cell_idx) && (cnt_dec < CNT_W'(WINDOW_LEN))) begin
      cnt_nxt = cnt_dec + CNT_W'(1);
    end
  end

  // At reset the whole window counts as "no key".
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= (cell_idx == '0) ? CNT_W'(WINDOW_LEN) : '0;
    end else if (upd) begin
      cnt_r <= cnt_nxt;
    end
  end

  // Strictly larger wins, so the lowest code keeps a tie.
  always_comb begin
    best_out = best_in;
    if (cnt_r > best_in.cnt) begin
      best_out.idx = cell_idx;
      best_out.cnt = cnt_r;
    end
  end

endmodule

>>> sim/keypad_debounce_checker.sv
// ---------------------------------------------------------------------------
// Keypad debounce checker
// Watches both channels and the threshold port of the keypad scanner. It
// keeps its own copy of the code window, the per-code tallies and the held
// flag, and it works out the report for every word taken. Each report
// taken from the block is checked, field by field, against the oldest
// report still waiting.
// ---------------------------------------------------------------------------
module keypad_debounce_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [kpd_pkg::THR_W-1:0]    cfg_wdata,
  input  logic                         in_valid,
  input  logic                         in_stall,
  input  logic [kpd_pkg::MATRIX_W-1:0] in_switch_matrix,
  input  logic                         out_valid,
  input  logic                         out_stall,
  input  logic [kpd_pkg::CODE_W-1:0]   out_stable_key,
  input  logic [kpd_pkg::CHAR_W-1:0]   out_stable_char,
  input  logic                         out_press_event,
  input  logic [kpd_pkg::CODE_W-1:0]   out_raw_key,
  output int                           fail_count,
  output int                           reports_pending
);
  import kpd_pkg::*;

  localparam logic [CODE_W-1:0] NO_KEY = '0;

  // Legends in code order: column-major, row 1 first.
  localparam logic [CHAR_W-1:0] KEY_LEGEND [KEY_CODES] = '{
    7'h00, 7'h31, 7'h34, 7'h37, 7'h2A, 7'h32, 7'h35,
    7'h38, 7'h30, 7'h33, 7'h36, 7'h39, 7'h23
  };

  typedef struct packed {
    logic [CODE_W-1:0] stable_key;
    logic [CHAR_W-1:0] stable_char;
    logic              press_event;
    logic [CODE_W-1:0] raw_key;
  } key_report_t;

  // Shadow of the block's state.
  logic [CODE_W-1:0] code_hist [WINDOW_LEN];
  logic [CNT_W-1:0]  code_tally [KEY_CODES];
  logic              key_down;
  logic [THR_W-1:0]  threshold;

  key_report_t expected_reports [$];
  key_report_t want;
  int          failures = 0;

  initial begin
    fail_count      = 0;
    reports_pending = 0;
  end

  // One tick of the scanner: encode, slide the window, retally, pick the
  // winning code and track the press edge.
  function automatic key_report_t debounce_tick(input logic [MATRIX_W-1:0] m);
    key_report_t       r;
    logic [CODE_W-1:0] raw;
    logic [CODE_W-1:0] oldest;
    logic [CODE_W-1:0] best_code;
    logic [CNT_W-1:0]  best_cnt;
    int                b;
    int                i;
    raw = NO_KEY;
    for (b = MATRIX_W - 1; b >= 0; b--) begin
      if (m[b] && b + 1 < KEY_CODES) begin
        raw = CODE_W'(b + 1);
      end
    end
    oldest = code_hist[0];
    if (code_tally[oldest] != 0) begin
      code_tally[oldest] = code_tally[oldest] - 1'b1;
    end
    if (code_tally[raw] < WINDOW_LEN) begin
      code_tally[raw] = code_tally[raw] + 1'b1;
    end
    for (i = 0; i < WINDOW_LEN - 1; i++) begin
      code_hist[i] = code_hist[i + 1];
    end
    code_hist[WINDOW_LEN - 1] = raw;
    // Strict comparison keeps the lowest code among equal tallies.
    best_code = NO_KEY;
    best_cnt  = '0;
    for (i = 0; i < KEY_CODES; i++) begin
      if (code_tally[i] > best_cnt) begin
        best_cnt  = code_tally[i];
        best_code = CODE_W'(i);
      end
    end
    r.raw_key     = raw;
    r.stable_key  = (best_cnt >= threshold) ? best_code : NO_KEY;
    r.stable_char = KEY_LEGEND[r.stable_key];
    r.press_event = 1'b0;
    if (r.stable_key == NO_KEY) begin
      key_down = 1'b0;
    end else if (!key_down) begin
      key_down      = 1'b1;
      r.press_event = 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < WINDOW_LEN; i++) begin
        code_hist[i] = NO_KEY;
      end
      for (int i = 0; i < KEY_CODES; i++) begin
        code_tally[i] = '0;
      end
      code_tally[NO_KEY] = CNT_W'(WINDOW_LEN);
      key_down  = 1'b0;
      threshold = THR_RESET;
      expected_reports.delete();
    end else begin
      // Compare the report taken at this edge before adding any new word.
      if (out_valid && !out_stall) begin
        if (expected_reports.size() == 0) begin
          $error("unexpected report: stable_key %0d raw_key %0d",
                 out_stable_key, out_raw_key);
          failures++;
        end else begin
          want = expected_reports.pop_front();
          if (want.stable_key !== out_stable_key) begin
            $error("stable_key: expected %0d, got %0d", want.stable_key, out_stable_key);
            failures++;
          end
          if (want.stable_char !== out_stable_char) begin
            $error("stable_char: expected %0d, got %0d", want.stable_char, out_stable_char);
            failures++;
          end
          if (want.press_event !== out_press_event) begin
            $error("press_event: expected %0d, got %0d", want.press_event, out_press_event);
            failures++;
          end
          if (want.raw_key !== out_raw_key) begin
            $error("raw_key: expected %0d, got %0d", want.raw_key, out_raw_key);
            failures++;
          end
        end
      end
      if (cfg_we) begin
        threshold = cfg_wdata;
      end
      if (in_valid && !in_stall) begin
        expected_reports.push_back(debounce_tick(in_switch_matrix));
      end
    end
    reports_pending <= expected_reports.size();
    fail_count      <= failures;
  end

endmodule

>>> sim/keypad_scan_majority_debounce_tb.sv
// ---------------------------------------------------------------------------
// Keypad scan with majority debounce: testbench
// Sends a directed run over every key and the matrix extremes, then random
// press, bounce and release sequences mixed with noise words under each
// press threshold. Both channels idle at random; the checker beside the
// block predicts and compares every report.
// ---------------------------------------------------------------------------
module keypad_scan_majority_debounce_tb;
  import kpd_pkg::*;

  localparam int HALF_PERIOD  = 6;
  localparam int RESET_CYCLES = 9;
  localparam int CYCLE_LIMIT  = 100000;
  localparam int PHASE_WORDS  = 256;
  localparam int DRAIN_CYCLES = 4;

  logic                clk              = 1'b0;
  logic                rst_n            = 1'b0;
  logic                cfg_we           = 1'b0;
  logic [THR_W-1:0]    cfg_wdata        = '0;
  logic                in_valid         = 1'b0;
  logic                in_stall;
  logic [MATRIX_W-1:0] in_switch_matrix = '0;
  logic                out_valid;
  logic                out_stall        = 1'b0;
  logic [CODE_W-1:0]   out_stable_key;
  logic [CHAR_W-1:0]   out_stable_char;
  logic                out_press_event;
  logic [CODE_W-1:0]   out_raw_key;

  int   fail_count;
  int   reports_pending;
  int   words_sent = 0;
  int   cycle_count = 0;
  logic quiet = 1'b0;

  always #HALF_PERIOD clk = ~clk;

  keypad_scan_majority_debounce dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_switch_matrix (in_switch_matrix),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stable_key   (out_stable_key),
    .out_stable_char  (out_stable_char),
    .out_press_event  (out_press_event),
    .out_raw_key      (out_raw_key)
  );

  keypad_debounce_checker checker_i (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_we           (cfg_we),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_switch_matrix (in_switch_matrix),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_stable_key   (out_stable_key),
    .out_stable_char  (out_stable_char),
    .out_press_event  (out_press_event),
    .out_raw_key      (out_raw_key),
    .fail_count       (fail_count),
    .reports_pending  (reports_pending)
  );

  // The receiver stalls now and then, except during the quiet stretch.
  always @(posedge clk) begin
    out_stall <= !quiet && ($urandom_range(99) < 8);
  end

  // Guard against a hang.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("keypad_scan_majority_debounce_tb: FAIL");
      $finish;
    end
  end

  // Offer one word, possibly after a short gap, and wait until it is taken.
  task automatic send_word(input logic [MATRIX_W-1:0] m);
    int gap;
    if (!quiet && $urandom_range(99) < 8) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_switch_matrix <= m;
    do @(posedge clk); while (in_stall);
    words_sent++;
  endtask

  // Change the threshold once every report in flight has come back.
  task automatic set_threshold(input logic [THR_W-1:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // A matrix that scans as the given code: its bit set, lower bits clear,
  // and higher bits either clear or random.
  function automatic logic [MATRIX_W-1:0] key_matrix(input int code);
    logic [MATRIX_W-1:0] upper;
    upper = MATRIX_W'($urandom);
    if (code == 0) begin
      return '0;
    end
    if ($urandom_range(1) == 0) begin
      upper = '0;
    end
    return ((upper >> code) << code) | (MATRIX_W'(1) << (code - 1));
  endfunction

  // Mostly press sequences (bounce, hold, bounce, release) with random
  // content; the rest are bursts of arbitrary matrix words.
  task automatic press_sequences(input int target);
    int code;
    int n;
    while (words_sent < target) begin
      if ($urandom_range(99) < 20) begin
        n = $urandom_range(1, 4);
        repeat (n) send_word(MATRIX_W'($urandom));
      end else begin
        code = $urandom_range(1, 12);
        n = $urandom_range(0, 3);
        repeat (n) begin
          send_word($urandom_range(1) ? key_matrix(code)
                                      : key_matrix($urandom_range(0, 12)));
        end
        n = $urandom_range(1, 6);
        repeat (n) send_word(key_matrix(code));
        n = $urandom_range(0, 2);
        repeat (n) send_word($urandom_range(1) ? key_matrix(code) : '0);
        n = $urandom_range(1, 4);
        repeat (n) send_word('0);
      end
    end
  endtask

  initial begin
    int k;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: all switches closed, then every key held for two ticks,
    // then release and a few lone or clashing codes under the reset
    // threshold.
    send_word('1);
    send_word('1);
    for (k = 2; k <= 12; k++) begin
      send_word(MATRIX_W'(1) << (k - 1));
      send_word(MATRIX_W'(1) << (k - 1));
    end
    send_word('0);
    send_word('0);
    send_word(12'h800);
    send_word(12'hA00);

    // Random phases, one per threshold; the second runs without idling.
    set_threshold(THR_W'(3));
    press_sequences(words_sent + PHASE_WORDS);
    set_threshold(THR_W'(1));
    quiet <= 1'b1;
    press_sequences(words_sent + PHASE_WORDS);
    quiet <= 1'b0;
    set_threshold(THR_W'(0));
    press_sequences(words_sent + PHASE_WORDS);
    set_threshold(THR_W'(2));
    press_sequences(words_sent + PHASE_WORDS);

    // Drain and give the verdict.
    in_valid <= 1'b0;
    do @(posedge clk); while (reports_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0 && reports_pending == 0) begin
      $display("keypad_scan_majority_debounce_tb: PASS");
    end else begin
      $display("keypad_scan_majority_debounce_tb: FAIL");
    end
    $finish;
  end

endmodule
